FILE: hdl/mprq_pkg.sv
// ----------------------------------------------------------------------------
// mprq_pkg
// Shared sizes, codes and types of the multilevel priority run queue.
// ----------------------------------------------------------------------------
package mprq_pkg;

    localparam int NUM_LEVELS  = 32;
    localparam int NUM_THREADS = 64;

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int HINT_W = $clog2(NUM_LEVELS + 1);
    localparam int TID_W  = $clog2(NUM_THREADS);
    localparam int CNT_W  = $clog2(NUM_THREADS + 1);
    localparam int PRIO_W = 6;
    localparam int RUNP_W = 5;
    localparam int STAT_W = 3;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    typedef enum logic [1:0] {
        ACT_ENQ = 2'd0,
        ACT_DEQ = 2'd1,
        ACT_REM = 2'd2,
        ACT_CHK = 2'd3
    } action_t;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STAT_W-1:0] ST_CLAMP = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTQ  = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUP   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ENQ_LINK,
        S_DEQ_POP,
        S_DEQ_HEAD,
        S_REM_LVL,
        S_REM_UNLINK,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic              first_slice;
        logic [RUNP_W-1:0] running_priority;
        logic              preempt_ok;
        logic [PRIO_W-1:0] priority_req;
        logic [TID_W-1:0]  thread_id;
        action_t           action;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              decision;
        logic [TID_W-1:0]  chosen_thread;
    } res_t;

endpackage

FILE: hdl/mprq_level_find.sv
// ----------------------------------------------------------------------------
// mprq_level_find
// Priority encoder: lowest non-empty level at or above a start level.
// ----------------------------------------------------------------------------
module mprq_level_find (
    input  logic [mprq_pkg::NUM_LEVELS-1:0] nonempty,
    input  logic [mprq_pkg::HINT_W-1:0]     start,
    output logic [mprq_pkg::HINT_W-1:0]     level
);
    import mprq_pkg::*;

    // yields NUM_LEVELS when nothing qualifies
    always_comb begin
        level = HINT_W'(NUM_LEVELS);
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (nonempty[i] && (HINT_W'(i) >= start)) begin
                level = HINT_W'(i);
            end
        end
    end

endmodule

FILE: hdl/multilevel_priority_run_queue.sv
// ----------------------------------------------------------------------------
// multilevel_priority_run_queue
// One FIFO of thread ids per priority level, kept as linked lists in memory.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream: tuser carries the action (enqueue,
// dequeue, remove, switch check), tdata the thread id and priorities.
// Every command transfer produces exactly one result transfer on the m_
// stream: chosen thread, decision bit and status code.
// Per-level head/tail pointers, per-thread links and the thread levels sit
// in synchronous memories with a registered read; each command walks a short
// read-modify-write sequence over them, one command at a time.
// After the execute state, errors and switch checks go straight to the result
// push; enqueue passes the link state, dequeue the pop and head states, and
// remove the level and unlink states. A new command is taken the cycle after
// the result is loaded, never while one is still being worked on.
// Reset empties all levels and sets the level hint to the level count; the
// memories are not cleared and are only read under the occupancy bits.
// When the receiver stalls, the result waits in the output register; the next
// command is still taken and worked, then its result waits in the push state.
// ----------------------------------------------------------------------------
module multilevel_priority_run_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // thread_id, priority_req, preempt_ok, running_priority, first_slice
    input  logic [mprq_pkg::S_DATA_W-1:0]   s_tdata,
    // action
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // chosen_thread, decision, status
    output logic [mprq_pkg::M_DATA_W-1:0]   m_tdata
);
    import mprq_pkg::*;

    state_t                  state_reg, state_next;
    in_item_t                in_reg, in_next;
    logic [NUM_LEVELS-1:0]   nonempty_reg, nonempty_next;
    logic [NUM_THREADS-1:0]  queued_reg, queued_next;
    logic [CNT_W-1:0]        total_reg, total_next;
    logic [HINT_W-1:0]       hint_reg, hint_next;
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [TID_W-1:0]        nx_reg, nx_next;
    logic [TID_W-1:0]        pv_reg, pv_next;
    logic                    last_reg, last_next;
    res_t                    res_reg, res_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    res_t                    m_res_reg, m_res_next;

    // memories
    logic [TID_W-1:0] head_mem [NUM_LEVELS];
    logic [TID_W-1:0] tail_mem [NUM_LEVELS];
    logic [TID_W-1:0] next_mem [NUM_THREADS];
    logic [TID_W-1:0] prev_mem [NUM_THREADS];
    logic [LVL_W-1:0] lvl_mem  [NUM_THREADS];

    logic [LVL_W-1:0] hd_ra, hd_wa, tl_ra, tl_wa;
    logic [TID_W-1:0] hd_wd, tl_wd, hd_q, tl_q;
    logic             hd_we, tl_we;
    logic [TID_W-1:0] nx_ra, nx_wa, nx_wd, nx_q;
    logic [TID_W-1:0] pv_ra, pv_wa, pv_wd, pv_q;
    logic [TID_W-1:0] lv_ra, lv_wa;
    logic [LVL_W-1:0] lv_wd, lv_q;
    logic             nx_we, pv_we, lv_we;

    logic              accept;
    logic              out_free;
    logic [HINT_W-1:0] found_lvl;
    logic [LVL_W-1:0]  lvl_c;
    logic              clamped;
    logic              tid_ok;
    logic              enq_err, rem_err, deq_none;
    logic              stale;
    logic [HINT_W-1:0] chk_hint;
    logic              is_head, is_tail;

    always_ff @(posedge aclk) begin
        if (hd_we) begin
            head_mem[hd_wa] <= hd_wd;
        end
        hd_q <= head_mem[hd_ra];
    end

    always_ff @(posedge aclk) begin
        if (tl_we) begin
            tail_mem[tl_wa] <= tl_wd;
        end
        tl_q <= tail_mem[tl_ra];
    end

    always_ff @(posedge aclk) begin
        if (nx_we) begin
            next_mem[nx_wa] <= nx_wd;
        end
        nx_q <= next_mem[nx_ra];
    end

    always_ff @(posedge aclk) begin
        if (pv_we) begin
            prev_mem[pv_wa] <= pv_wd;
        end
        pv_q <= prev_mem[pv_ra];
    end

    always_ff @(posedge aclk) begin
        if (lv_we) begin
            lvl_mem[lv_wa] <= lv_wd;
        end
        lv_q <= lvl_mem[lv_ra];
    end

    mprq_level_find u_find (
        .nonempty (nonempty_reg),
        .start    (hint_reg),
        .level    (found_lvl)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign clamped  = in_reg.priority_req > PRIO_W'(NUM_LEVELS - 1);
    assign lvl_c    = clamped ? LVL_W'(NUM_LEVELS - 1) : in_reg.priority_req[LVL_W-1:0];
    assign tid_ok   = 32'(in_reg.thread_id) < NUM_THREADS;
    assign enq_err  = !tid_ok || queued_reg[in_reg.thread_id];
    assign rem_err  = !tid_ok || !queued_reg[in_reg.thread_id];
    assign deq_none = (total_reg == '0) || (found_lvl >= HINT_W'(NUM_LEVELS));
    assign stale    = (hint_reg >= HINT_W'(NUM_LEVELS))
                      || !nonempty_reg[hint_reg[LVL_W-1:0]];
    assign chk_hint = (stale && (total_reg != '0)) ? found_lvl : hint_reg;
    assign is_head  = hd_q == in_reg.thread_id;
    assign is_tail  = tl_q == in_reg.thread_id;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (in_reg.action)
                    ACT_ENQ: state_next = enq_err ? S_PUSH : S_ENQ_LINK;
                    ACT_DEQ: state_next = deq_none ? S_PUSH : S_DEQ_POP;
                    ACT_REM: state_next = rem_err ? S_PUSH : S_REM_LVL;
                    default: state_next = S_PUSH;
                endcase
            end
            S_ENQ_LINK:   state_next = S_PUSH;
            S_DEQ_POP:    state_next = S_DEQ_HEAD;
            S_DEQ_HEAD:   state_next = S_PUSH;
            S_REM_LVL:    state_next = S_REM_UNLINK;
            S_REM_UNLINK: state_next = S_PUSH;
            S_PUSH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        in_next       = in_reg;
        nonempty_next = nonempty_reg;
        queued_next   = queued_reg;
        total_next    = total_reg;
        hint_next     = hint_reg;
        lvl_next      = lvl_reg;
        nx_next       = nx_reg;
        pv_next       = pv_reg;
        last_next     = last_reg;
        res_next      = res_reg;
        m_res_next    = m_res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;

        hd_ra = '0; hd_we = 1'b0; hd_wa = '0; hd_wd = '0;
        tl_ra = '0; tl_we = 1'b0; tl_wa = '0; tl_wd = '0;
        nx_ra = '0; nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
        pv_ra = '0; pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
        lv_ra = '0; lv_we = 1'b0; lv_wa = '0; lv_wd = '0;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    in_next.action           = action_t'(s_tuser);
                    in_next.thread_id        = s_tdata[5:0];
                    in_next.priority_req     = s_tdata[11:6];
                    in_next.preempt_ok       = s_tdata[12];
                    in_next.running_priority = s_tdata[17:13];
                    in_next.first_slice      = s_tdata[18];
                end
            end
            S_EXEC: begin
                res_next = '0;
                case (in_reg.action)
                    ACT_ENQ: begin
                        if (!tid_ok) begin
                            res_next.status = ST_NOTQ;
                        end else if (enq_err) begin
                            res_next.status = ST_DUP;
                        end else begin
                            lvl_next = lvl_c;
                            tl_ra    = lvl_c;
                            nx_we    = 1'b1;
                            nx_wa    = in_reg.thread_id;
                            nx_wd    = in_reg.thread_id;
                            lv_we    = 1'b1;
                            lv_wa    = in_reg.thread_id;
                            lv_wd    = lvl_c;
                            if (!nonempty_reg[lvl_c]) begin
                                hd_we = 1'b1;
                                hd_wa = lvl_c;
                                hd_wd = in_reg.thread_id;
                                pv_we = 1'b1;
                                pv_wa = in_reg.thread_id;
                                pv_wd = in_reg.thread_id;
                            end
                        end
                    end
                    ACT_DEQ: begin
                        if (deq_none) begin
                            res_next.status = ST_EMPTY;
                        end else begin
                            lvl_next = found_lvl[LVL_W-1:0];
                            hd_ra    = found_lvl[LVL_W-1:0];
                            tl_ra    = found_lvl[LVL_W-1:0];
                        end
                    end
                    ACT_REM: begin
                        if (rem_err) begin
                            res_next.status = ST_NOTQ;
                        end else begin
                            lv_ra = in_reg.thread_id;
                            nx_ra = in_reg.thread_id;
                            pv_ra = in_reg.thread_id;
                        end
                    end
                    default: begin
                        if (!in_reg.first_slice) begin
                            hint_next         = chk_hint;
                            res_next.decision = chk_hint <= in_reg.priority_req;
                        end
                    end
                endcase
            end
            S_ENQ_LINK: begin
                // tail read of this level is valid now
                if (nonempty_reg[lvl_reg]) begin
                    nx_we = 1'b1;
                    nx_wa = tl_q;
                    nx_wd = in_reg.thread_id;
                    pv_we = 1'b1;
                    pv_wa = in_reg.thread_id;
                    pv_wd = tl_q;
                end
                tl_we = 1'b1;
                tl_wa = lvl_reg;
                tl_wd = in_reg.thread_id;
                nonempty_next[lvl_reg]        = 1'b1;
                queued_next[in_reg.thread_id] = 1'b1;
                if ((HINT_W'(lvl_reg) < hint_reg) || (total_reg == '0)) begin
                    hint_next = HINT_W'(lvl_reg);
                end
                total_next        = total_reg + CNT_W'(1);
                res_next.status   = clamped ? ST_CLAMP : ST_OK;
                res_next.decision = in_reg.preempt_ok
                                    && (in_reg.priority_req <= PRIO_W'(in_reg.running_priority));
            end
            S_DEQ_POP: begin
                nx_ra     = hd_q;
                last_next = tl_q == hd_q;
                if (tl_q == hd_q) begin
                    nonempty_next[lvl_reg] = 1'b0;
                end
                queued_next[hd_q]      = 1'b0;
                total_next             = total_reg - CNT_W'(1);
                hint_next              = HINT_W'(lvl_reg);
                res_next.chosen_thread = hd_q;
                res_next.status        = ST_OK;
            end
            S_DEQ_HEAD: begin
                if (!last_reg) begin
                    hd_we = 1'b1;
                    hd_wa = lvl_reg;
                    hd_wd = nx_q;
                end
            end
            S_REM_LVL: begin
                lvl_next = lv_q;
                nx_next  = nx_q;
                pv_next  = pv_q;
                hd_ra    = lv_q;
                tl_ra    = lv_q;
            end
            S_REM_UNLINK: begin
                if (is_head && is_tail) begin
                    nonempty_next[lvl_reg] = 1'b0;
                end else if (is_head) begin
                    hd_we = 1'b1;
                    hd_wa = lvl_reg;
                    hd_wd = nx_reg;
                end else if (is_tail) begin
                    tl_we = 1'b1;
                    tl_wa = lvl_reg;
                    tl_wd = pv_reg;
                end else begin
                    nx_we = 1'b1;
                    nx_wa = pv_reg;
                    nx_wd = nx_reg;
                    pv_we = 1'b1;
                    pv_wa = nx_reg;
                    pv_wd = pv_reg;
                end
                queued_next[in_reg.thread_id] = 1'b0;
                total_next                    = total_reg - CNT_W'(1);
                res_next.status               = ST_OK;
            end
            S_PUSH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_res_next    = res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nonempty_reg <= '0;
            queued_reg   <= '0;
            total_reg    <= '0;
            hint_reg     <= HINT_W'(NUM_LEVELS);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nonempty_reg <= nonempty_next;
            queued_reg   <= queued_next;
            total_reg    <= total_next;
            hint_reg     <= hint_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg    <= in_next;
        lvl_reg   <= lvl_next;
        nx_reg    <= nx_next;
        pv_reg    <= pv_next;
        last_reg  <= last_next;
        res_reg   <= res_next;
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_DATA_W - $bits(res_t))'(0), m_res_reg};

endmodule

FILE: test/run_queue_checker.sv
// ----------------------------------------------------------------------------
// run_queue_checker
// Watches both streams of the run queue, predicts every result and compares.
// ----------------------------------------------------------------------------
// Each accepted command transfer is applied to a shadow of the per-level
// FIFOs (head/tail pointers, thread links, occupancy bits, thread count and
// level hint), and the result it must produce is queued. Each result transfer
// is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module run_queue_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mprq_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mprq_pkg::M_DATA_W-1:0]   m_tdata,
    output int                              fail_count,
    output int                              pending
);
    import mprq_pkg::*;

    logic [TID_W-1:0]       lvl_head  [NUM_LEVELS];
    logic [TID_W-1:0]       lvl_tail  [NUM_LEVELS];
    logic [NUM_LEVELS-1:0]  lvl_busy;
    logic [TID_W-1:0]       link_next [NUM_THREADS];
    logic [TID_W-1:0]       link_prev [NUM_THREADS];
    logic [LVL_W-1:0]       level_of  [NUM_THREADS];
    logic [NUM_THREADS-1:0] is_queued;
    int                     queued_count;
    int                     hint;
    int                     mismatches;
    res_t                   expected_results [$];
    in_item_t               cmd;
    res_t                   predicted;
    res_t                   want;
    res_t                   got;

    initial begin
        fail_count = 0;
        pending    = 0;
        mismatches = 0;
    end

    function automatic int first_busy_level(int start);
        for (int l = start; l < NUM_LEVELS; l++) begin
            if (lvl_busy[l]) return l;
        end
        return NUM_LEVELS;
    endfunction

    task automatic schedule_step(input in_item_t c, output res_t r);
        int               lvl;
        logic [TID_W-1:0] t;
        logic [TID_W-1:0] p;
        logic [TID_W-1:0] n;
        r = '0;
        case (c.action)
            ACT_ENQ: begin
                if (is_queued[c.thread_id]) begin
                    r.status = ST_DUP;
                end else begin
                    lvl = int'(c.priority_req);
                    if (lvl > NUM_LEVELS - 1) begin
                        lvl = NUM_LEVELS - 1;
                        r.status = ST_CLAMP;
                    end
                    if (lvl_busy[lvl]) begin
                        link_next[lvl_tail[lvl]] = c.thread_id;
                        link_prev[c.thread_id] = lvl_tail[lvl];
                    end else begin
                        lvl_head[lvl] = c.thread_id;
                        link_prev[c.thread_id] = c.thread_id;
                        lvl_busy[lvl] = 1'b1;
                    end
                    lvl_tail[lvl] = c.thread_id;
                    link_next[c.thread_id] = c.thread_id;
                    level_of[c.thread_id] = lvl[LVL_W-1:0];
                    is_queued[c.thread_id] = 1'b1;
                    if (lvl < hint || queued_count == 0) hint = lvl;
                    queued_count++;
                    r.decision = c.preempt_ok && (c.priority_req <= c.running_priority);
                end
            end
            ACT_DEQ: begin
                lvl = (queued_count == 0) ? NUM_LEVELS : first_busy_level(hint);
                if (lvl >= NUM_LEVELS) begin
                    r.status = ST_EMPTY;
                end else begin
                    t = lvl_head[lvl];
                    if (lvl_tail[lvl] == t) lvl_busy[lvl] = 1'b0;
                    else lvl_head[lvl] = link_next[t];
                    is_queued[t] = 1'b0;
                    queued_count--;
                    hint = lvl;
                    r.chosen_thread = t;
                end
            end
            ACT_REM: begin
                if (!is_queued[c.thread_id]) begin
                    r.status = ST_NOTQ;
                end else begin
                    lvl = int'(level_of[c.thread_id]);
                    t = c.thread_id;
                    if (lvl_head[lvl] == t && lvl_tail[lvl] == t) begin
                        lvl_busy[lvl] = 1'b0;
                    end else if (lvl_head[lvl] == t) begin
                        lvl_head[lvl] = link_next[t];
                    end else if (lvl_tail[lvl] == t) begin
                        lvl_tail[lvl] = link_prev[t];
                    end else begin
                        p = link_prev[t];
                        n = link_next[t];
                        link_next[p] = n;
                        link_prev[n] = p;
                    end
                    is_queued[t] = 1'b0;
                    queued_count--;
                end
            end
            ACT_CHK: begin
                if (!c.first_slice) begin
                    // refresh the hint only when threads are queued and it points at an empty level or past the last
                    if ((hint >= NUM_LEVELS || !lvl_busy[hint]) && queued_count > 0)
                        hint = first_busy_level(hint);
                    r.decision = (hint <= c.priority_req);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                lvl_head[i] = '0;
                lvl_tail[i] = '0;
            end
            for (int i = 0; i < NUM_THREADS; i++) begin
                link_next[i] = '0;
                link_prev[i] = '0;
                level_of[i]  = '0;
            end
            lvl_busy     = '0;
            is_queued    = '0;
            queued_count = 0;
            hint         = NUM_LEVELS;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[$bits(res_t)-1:0]);
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result transfer: thread %0d",
                                 got.chosen_thread, " decision %0d status %0d",
                                 got.decision, got.status);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.chosen_thread !== want.chosen_thread ||
                        got.decision !== want.decision || got.status !== want.status) begin
                        if (mismatches < 10)
                            $display("result mismatch: expected thread %0d decision %0d",
                                     want.chosen_thread, want.decision,
                                     " status %0d, got thread %0d", want.status,
                                     got.chosen_thread, " decision %0d status %0d",
                                     got.decision, got.status);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                cmd.action           = action_t'(s_tuser);
                cmd.thread_id        = s_tdata[5:0];
                cmd.priority_req     = s_tdata[11:6];
                cmd.preempt_ok       = s_tdata[12];
                cmd.running_priority = s_tdata[17:13];
                cmd.first_slice      = s_tdata[18];
                schedule_step(cmd, predicted);
                expected_results.push_back(predicted);
            end
        end
        pending    <= expected_results.size();
        fail_count <= mismatches;
    end

endmodule

FILE: test/multilevel_priority_run_queue_tb.sv
// ----------------------------------------------------------------------------
// multilevel_priority_run_queue_tb
// Stimulus and verdict for the multilevel priority run queue.
// ----------------------------------------------------------------------------
// A directed sequence covers empty dequeues, clamped and duplicate enqueues,
// removal at head, middle and tail, stale hints and first-slice checks.
// Random bursts then pick at random between filling, draining and a mix,
// mostly on a few neighboring priorities so the FIFOs get deep. Both sides
// of the handshake idle at random in the first two of three phases, not in
// the last; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module multilevel_priority_run_queue_tb;
    import mprq_pkg::*;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    int tx_idle_pct = 17;
    int rx_idle_pct = 80;
    int fail_count;
    int pending;
    int drain_cycles;

    multilevel_priority_run_queue DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    run_queue_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one command transfer, optionally preceded by an idle gap
    task automatic send_cmd(action_t act, logic [TID_W-1:0] tid, logic [PRIO_W-1:0] prio,
                            logic pre, logic [RUNP_W-1:0] runp, logic fq);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, fq, runp, pre, prio, tid};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic random_bursts(int bursts);
        int               mode;
        int               enq_w;
        int               deq_w;
        int               rem_w;
        int               base;
        int               pick;
        action_t          act;
        logic [PRIO_W-1:0] prio;
        for (int b = 0; b < bursts; b++) begin
            mode = $urandom_range(2);
            base = $urandom_range(29);
            case (mode)
                0: begin
                    enq_w = 60; deq_w = 15; rem_w = 15;
                end
                1: begin
                    enq_w = 15; deq_w = 45; rem_w = 25;
                end
                default: begin
                    enq_w = 35; deq_w = 30; rem_w = 20;
                end
            endcase
            for (int i = 0; i < 16; i++) begin
                pick = $urandom_range(99);
                if (pick < enq_w) act = ACT_ENQ;
                else if (pick < enq_w + deq_w) act = ACT_DEQ;
                else if (pick < enq_w + deq_w + rem_w) act = ACT_REM;
                else act = ACT_CHK;
                pick = $urandom_range(99);
                if (pick < 70) prio = PRIO_W'(base + int'($urandom_range(2)));
                else if (pick < 90) prio = PRIO_W'($urandom_range(31));
                else prio = PRIO_W'($urandom_range(63, 32));
                send_cmd(act, TID_W'($urandom_range(63)), prio, 1'($urandom_range(1)),
                         RUNP_W'($urandom_range(31)), ($urandom_range(99) < 30));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        send_cmd(ACT_DEQ, 6'd9,  6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_CHK, 6'd0,  6'd63, 1'b0, 5'd0,  1'b0);
        send_cmd(ACT_CHK, 6'd0,  6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_REM, 6'd5,  6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_ENQ, 6'd63, 6'd63, 1'b1, 5'd31, 1'b0);
        send_cmd(ACT_ENQ, 6'd0,  6'd0,  1'b1, 5'd0,  1'b0);
        send_cmd(ACT_ENQ, 6'd0,  6'd4,  1'b1, 5'd31, 1'b0);
        send_cmd(ACT_ENQ, 6'd1,  6'd0,  1'b0, 5'd31, 1'b0);
        send_cmd(ACT_ENQ, 6'd2,  6'd0,  1'b0, 5'd31, 1'b1);
        send_cmd(ACT_ENQ, 6'd3,  6'd0,  1'b1, 5'd31, 1'b0);
        send_cmd(ACT_REM, 6'd2,  6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_REM, 6'd3,  6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_REM, 6'd0,  6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_ENQ, 6'd10, 6'd31, 1'b1, 5'd31, 1'b0);
        send_cmd(ACT_CHK, 6'd0,  6'd63, 1'b0, 5'd0,  1'b1);
        send_cmd(ACT_DEQ, 6'd0,  6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_DEQ, 6'd0,  6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_DEQ, 6'd0,  6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_DEQ, 6'd0,  6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_ENQ, 6'd20, 6'd5,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_ENQ, 6'd21, 6'd9,  1'b1, 5'd9,  1'b0);
        send_cmd(ACT_DEQ, 6'd0,  6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_CHK, 6'd0,  6'd9,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_REM, 6'd21, 6'd0,  1'b0, 5'd0,  1'b0);
        send_cmd(ACT_CHK, 6'd0,  6'd8,  1'b0, 5'd0,  1'b0);

        random_bursts(22);
        tx_idle_pct = 80;
        rx_idle_pct = 17;
        random_bursts(22);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_bursts(22);
        s_tvalid <= 1'b0;

        drain_cycles = 0;
        do begin
            @(posedge aclk);
            drain_cycles++;
        end while (pending != 0 && drain_cycles < 5000);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("multilevel_priority_run_queue verification clean");
        else
            $display("multilevel_priority_run_queue verification failed");
        $finish;
    end

    initial begin
        #1000000;
        $display("multilevel_priority_run_queue verification failed");
        $finish;
    end

endmodule
